>>> rtl/tmcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcg_pkg: shared types and constants of the character generator
// Request, response, configuration and command types, the raster constants
// and the pixel doubling function.
// ----------------------------------------------------------------------------
package tmcg_pkg;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_RENDER = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        CFG_BASE_ADDR       = 3'd0,
        CFG_EIGHTY_COLUMNS  = 3'd1,
        CFG_WIDE_EXCESS     = 3'd2,
        CFG_UPPER_CASE_ROWS = 3'd3,
        CFG_FULL_SET        = 3'd4,
        CFG_REVERSE_VIDEO   = 3'd5,
        CFG_DISPLAY_ENABLE  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic        opcode;
        logic [11:0] rom_addr;
        logic [7:0]  rom_data;
        logic [7:0]  video_data;
    } t_req;

    typedef struct packed {
        logic [15:0] pixel_bits;
        logic [4:0]  pixel_count;
        logic [15:0] next_fetch_addr;
        logic        line_end;
        logic        frame_end;
    } t_rsp;

    typedef struct packed {
        logic [15:0] base_addr;
        logic        eighty_columns;
        logic        wide_excess;
        logic        upper_case_rows;
        logic        full_set;
        logic        reverse_video;
        logic        display_enable;
    } t_cfg;

    // One classified request as handed from the front end to the back end.
    typedef struct packed {
        logic        is_render;
        logic [11:0] addr;
        logic [7:0]  data;
        logic        invert;
        logic        strip;
        logic [15:0] next_addr;
        logic        line_end;
        logic        frame_end;
    } t_cmd;

    localparam int unsigned FRAME_LINES = 250;

    localparam logic [6:0] COLS_WIDE   = 7'd80;
    localparam logic [6:0] COLS_NARROW = 7'd40;
    localparam logic [4:0] EXCESS_WIDE   = 5'd24;
    localparam logic [4:0] EXCESS_NARROW = 5'd4;
    localparam logic [3:0] ROWS_UPPER = 4'd8;
    localparam logic [3:0] ROWS_FULL  = 4'd10;
    localparam logic [4:0] PIX_COUNT_WIDE   = 5'd8;
    localparam logic [4:0] PIX_COUNT_DOUBLE = 5'd16;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;

    // Each glyph pixel becomes two adjacent output pixels.
    function automatic logic [15:0] double_bits(input logic [7:0] v);
        logic [15:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            r[2*i]   = v[i];
            r[2*i+1] = v[i];
        end
        return r;
    endfunction

endpackage

>>> rtl/tmcg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcg_front: request classification and raster counters
// Turns each accepted request into a command; a render request also advances
// the row, column and line counters and works out the next fetch address.
// ----------------------------------------------------------------------------
module tmcg_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tmcg_pkg::t_cfg i_cfg,
    input  logic           i_accept,
    input  tmcg_pkg::t_req i_req,
    output tmcg_pkg::t_cmd o_cmd
);
    import tmcg_pkg::*;

    logic [3:0]  r_row, n_row;
    logic [6:0]  r_col, n_col;
    logic [7:0]  r_line, n_line;
    logic [15:0] r_line_base, n_line_base;

    logic [6:0]  cols;
    logic [3:0]  rows;
    logic [4:0]  excess;
    logic [15:0] base_eff;
    logic        frame_start, col_last, row_last, line_last, is_render;

    assign is_render   = (t_op'(i_req.opcode) == OP_RENDER);
    assign cols        = i_cfg.eighty_columns ? COLS_WIDE : COLS_NARROW;
    assign rows        = i_cfg.upper_case_rows ? ROWS_UPPER : ROWS_FULL;
    assign excess      = i_cfg.wide_excess ? EXCESS_WIDE : EXCESS_NARROW;
    assign frame_start = (r_row == '0) && (r_col == '0) && (r_line == '0);
    assign base_eff    = frame_start ? i_cfg.base_addr : r_line_base;
    // Counters at or past a limit that shrank mid-frame count as the last one.
    assign col_last    = ({1'b0, r_col} + 8'd1) >= {1'b0, cols};
    assign row_last    = ({1'b0, r_row} + 5'd1) >= {1'b0, rows};
    assign line_last   = ({1'b0, r_line} + 9'd1) >= 9'(FRAME_LINES);

    always_comb begin
        n_row       = r_row;
        n_col       = r_col + 7'd1;
        n_line      = r_line;
        n_line_base = base_eff;

        o_cmd           = '0;
        o_cmd.is_render = is_render;
        o_cmd.addr      = is_render
                        ? {r_row, i_req.video_data[7] & i_cfg.full_set, i_req.video_data[6:0]}
                        : i_req.rom_addr;
        o_cmd.data      = i_req.rom_data;
        o_cmd.invert    = i_req.video_data[7] & ~i_cfg.full_set;
        o_cmd.strip     = (i_req.video_data[6:5] != 2'b00) & ~i_cfg.upper_case_rows;
        o_cmd.next_addr = base_eff + 16'(n_col);

        if (col_last) begin
            n_col          = '0;
            o_cmd.line_end = 1'b1;
            if (line_last) begin
                o_cmd.frame_end = 1'b1;
                n_line          = '0;
                n_row           = '0;
                o_cmd.next_addr = i_cfg.base_addr;
            end else begin
                n_line = r_line + 8'd1;
                if (row_last) begin
                    n_row       = '0;
                    n_line_base = base_eff + 16'(cols) + 16'(excess);
                end else begin
                    n_row = r_row + 4'd1;
                end
                o_cmd.next_addr = n_line_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_line      <= '0;
            r_line_base <= '0;
        end else if (i_accept && is_render) begin
            r_row       <= n_row;
            r_col       <= n_col;
            r_line      <= n_line;
            r_line_base <= n_line_base;
        end
    end

endmodule

>>> rtl/tmcg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcg_queue: command queue between front and back end
// A small first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
module tmcg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tmcg_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output tmcg_pkg::t_cmd o_cmd
);
    import tmcg_pkg::*;

    t_cmd             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]    r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/tmcg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcg_back: glyph memory and pixel formatting
// Executes queued commands: loads write the glyph memory, renders read it
// and shape the pixels into the output register.
// ----------------------------------------------------------------------------
module tmcg_back #(
    parameter int unsigned GLYPH_ROM_DEPTH = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tmcg_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  tmcg_pkg::t_cmd i_q_cmd,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output tmcg_pkg::t_rsp o_rsp
);
    import tmcg_pkg::*;

    localparam int unsigned ROM_AW = $clog2(GLYPH_ROM_DEPTH);

    logic [7:0]  r_rom [GLYPH_ROM_DEPTH];
    logic [7:0]  r_rd;

    // Read stage: command attributes alongside the registered memory data.
    logic        r_s1_valid;
    t_cmd        r_s1_cmd;
    logic        r_s1_oob;

    logic        r_out_valid;
    t_rsp        r_out;

    logic        out_free, s1_adv, s1_free, in_range;
    logic [7:0]  glyph;
    t_rsp        n_out;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_q_pop  = i_q_valid && (!i_q_cmd.is_render || s1_free);
    assign in_range = (32'(i_q_cmd.addr) < GLYPH_ROM_DEPTH);

    always_ff @(posedge i_clk) begin
        if (o_q_pop && !i_q_cmd.is_render && in_range) begin
            r_rom[i_q_cmd.addr[ROM_AW-1:0]] <= i_q_cmd.data;
        end
        if (o_q_pop && i_q_cmd.is_render && in_range) begin
            r_rd <= r_rom[i_q_cmd.addr[ROM_AW-1:0]];
        end
    end

    always_comb begin
        glyph = r_s1_oob ? 8'h00 : r_rd;
        if (r_s1_cmd.invert) begin
            glyph = ~glyph;
        end
        if (r_s1_cmd.strip) begin
            glyph[0] = 1'b0;
        end
        if (i_cfg.reverse_video) begin
            glyph = ~glyph;
        end
        if (!i_cfg.display_enable) begin
            glyph = '0;
        end

        n_out                 = '0;
        n_out.next_fetch_addr = r_s1_cmd.next_addr;
        n_out.line_end        = r_s1_cmd.line_end;
        n_out.frame_end       = r_s1_cmd.frame_end;
        if (i_cfg.eighty_columns) begin
            n_out.pixel_bits  = {8'h00, glyph};
            n_out.pixel_count = PIX_COUNT_WIDE;
        end else begin
            n_out.pixel_bits  = double_bits(glyph);
            n_out.pixel_count = PIX_COUNT_DOUBLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_cmd.is_render) begin
            r_s1_cmd <= i_q_cmd;
            r_s1_oob <= !in_range;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= o_q_pop && i_q_cmd.is_render;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

>>> rtl/text_mode_character_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_character_generator: raster text-mode character generator
// Glyph memory loader plus per-cell pixel generator with raster counters.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on i_valid / i_req and are taken at an edge where
// i_valid is high and o_stall is low. A load request writes one byte of the
// glyph memory and gives no response; a render request gives exactly one
// response on o_valid / o_rsp, taken at an edge where i_stall is low.
// Responses come out in request order.
// A render request passes through the queue slot, the glyph memory read and
// then the output register before it is visible on o_valid.
// Throughput: one request per cycle sustained while the receiver does not
// stall. The front end computes the counters and the fetch address in the
// accept cycle; the back end makes at most one access to the single-port
// glyph memory per cycle, so a load and a render never compete for it.
// When the receiver stalls, the output register and read stage hold and the
// four-entry command queue absorbs further requests; o_stall rises only
// when that queue is full. Load requests at the head of the queue drain
// even while the output is stalled.
// Reset (synchronous, i_rst_n low) clears the counters, the line base, all
// configuration registers and the queue. The glyph memory is not cleared,
// so it must be loaded before any render request reads it.
// Configuration writes (i_cfg_we) take effect at once and should only be
// made while no request is in flight.
// ----------------------------------------------------------------------------
module text_mode_character_generator #(
    parameter int unsigned GLYPH_ROM_DEPTH = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // request channel
    input  logic           i_valid,
    output logic           o_stall,
    input  tmcg_pkg::t_req i_req,
    // response channel
    output logic           o_valid,
    input  logic           i_stall,
    output tmcg_pkg::t_rsp o_rsp,
    // configuration write port
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);
    import tmcg_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd, q_cmd;
    logic accept, q_full, q_valid, q_pop;

    // Configuration registers, one per index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BASE_ADDR:       r_cfg.base_addr       <= i_cfg_data;
                CFG_EIGHTY_COLUMNS:  r_cfg.eighty_columns  <= i_cfg_data[0];
                CFG_WIDE_EXCESS:     r_cfg.wide_excess     <= i_cfg_data[0];
                CFG_UPPER_CASE_ROWS: r_cfg.upper_case_rows <= i_cfg_data[0];
                CFG_FULL_SET:        r_cfg.full_set        <= i_cfg_data[0];
                CFG_REVERSE_VIDEO:   r_cfg.reverse_video   <= i_cfg_data[0];
                CFG_DISPLAY_ENABLE:  r_cfg.display_enable  <= i_cfg_data[0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    // The request side only waits for room in the queue.
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    tmcg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_accept(accept),
        .i_req   (i_req),
        .o_cmd   (front_cmd)
    );

    tmcg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tmcg_back #(
        .GLYPH_ROM_DEPTH(GLYPH_ROM_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_rsp     (o_rsp)
    );

    // A frame can only end on the last cell of a scan line.
    a_frame_on_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_rsp.frame_end || o_rsp.line_end))
        else $error("frame end without line end");

    // Undoubled cells leave the upper pixel byte clear.
    a_narrow_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.pixel_count == PIX_COUNT_WIDE) |-> (o_rsp.pixel_bits[15:8] == 8'h00))
        else $error("pixels beyond an 8-pixel cell");

    // The queue never pops while empty.
    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("command queue popped while empty");

    // Nothing is offered in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("response valid straight after reset");

endmodule
